// ===== hw/rtl/slid_pkg.sv =====
// Package for the sorted list block: sizes, command and status codes.
// Depends on nothing; the interfaces and the top level of the block import it.
`default_nettype none

package slid_pkg;

  localparam int DEPTH       = 16;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int VALUE_W     = 32;
  localparam int COMMAND_W   = 2;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 5;

  typedef enum logic [COMMAND_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_DUMP   = 2'd2
  } command_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/slid_cmd_if.sv =====
// Command channel of the sorted list block: valid, ready and one command.
// Depends on slid_pkg for the field widths.
`default_nettype none

interface slid_cmd_if import slid_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [COMMAND_W-1:0]       command;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/slid_res_if.sv =====
// Result channel of the sorted list block: valid, ready and one result.
// Depends on slid_pkg for the field widths.
`default_nettype none

interface slid_res_if import slid_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  entry_value;
  logic [STATUS_W-1:0]        status;
  logic [COUNT_OUT_W-1:0]     entry_count;
  logic                       last;

  modport source (output valid, output entry_value, output status, output entry_count,
                  output last, input ready);
  modport sink   (input valid, input entry_value, input status, input entry_count,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/slid_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stands alone; no package needed.
`default_nettype none

module slid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_list_insert_delete.sv =====
// Top level of the sorted list block: sequencer around one entry RAM.
// Depends on slid_pkg, slid_cmd_if, slid_res_if and slid_ram.
`default_nettype none

// A sorted list of up to DEPTH signed 32-bit values, held in ascending order.
// Commands arrive as transactions on the cmd channel: insert places the value
// after any equal entries, delete removes the first equal entry, dump emits
// every entry in order. Results leave as transactions on the res channel.
// Insert and delete give one status result each; dump gives one result per
// entry (one result with status empty for an empty list), with last set on
// the final one. An unused command code is taken and ignored.
// The block accepts one command at a time; cmd.ready is high only while the
// sequencer is idle. An insert is a backward walk that shifts entries up by
// one, one entry per cycle; a delete is a forward walk that shifts entries
// down; a dump emits the entries in order and holds while the receiver stalls.
// The pace is set by the single read and single write port of the RAM.
// The result register decouples the two sides: the next command is accepted
// while the previous result still waits. When the receiver stalls, the
// sequencer holds its place and the RAM read is repeated at the same address.
// Synchronous reset empties the list; the RAM contents are not cleared.
module sorted_list_insert_delete import slid_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  slid_cmd_if.sink   cmd,
  slid_res_if.source res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_PUT,
    S_DEL,
    S_DUMP,
    S_RESP
  } state_t;

  state_t                    state;
  logic [IDX_W-1:0]          idx;
  logic [CNT_W-1:0]          count;
  logic signed [VALUE_W-1:0] val;
  logic                      found;
  status_t                   resp_status;

  logic                      res_valid;
  logic signed [VALUE_W-1:0] res_value;
  status_t                   res_status;
  logic [COUNT_OUT_W-1:0]    res_count;
  logic                      res_last;

  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic [VALUE_W-1:0]        wr_data;
  logic [IDX_W-1:0]          rd_addr;
  logic [VALUE_W-1:0]        rd_data;

  logic [IDX_W-1:0]          last_idx;
  logic                      greater;
  logic                      match;
  logic                      out_free;
  logic                      res_load;

  slid_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Position of the highest held entry; only meaningful while count is nonzero.
  assign last_idx = IDX_W'(count - CNT_W'(1));
  assign greater  = $signed(rd_data) > val;
  assign match    = rd_data == $unsigned(val);
  // The result register can take a new result in this cycle.
  assign out_free = !res_valid || res.ready;
  // A result is loaded into the result register in this cycle.
  assign res_load = ((state == S_DUMP) || (state == S_RESP)) && out_free;

  assign cmd.ready       = state == S_IDLE;
  assign res.valid       = res_valid;
  assign res.entry_value = res_value;
  assign res.status      = res_status;
  assign res.entry_count = res_count;
  assign res.last        = res_last;

  // RAM control. The read data in each walking state belongs to entry idx, and
  // the address presented now fetches the entry the next cycle will need.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = rd_data;
    rd_addr = '0;
    case (state)
      S_IDLE: begin
        rd_addr = (cmd.command == CMD_INSERT) ? last_idx : '0;
      end
      S_INS: begin
        // Walking down: a larger entry moves up one place, otherwise the new
        // value lands just above the entry that is not larger.
        rd_addr = idx - IDX_W'(1);
        wr_en   = 1'b1;
        wr_addr = idx + IDX_W'(1);
        wr_data = greater ? rd_data : $unsigned(val);
      end
      S_INS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = idx;
        wr_data = $unsigned(val);
      end
      S_DEL: begin
        // Walking up: once the match is passed, every entry moves down one.
        rd_addr = idx + IDX_W'(1);
        wr_en   = found;
        wr_addr = idx - IDX_W'(1);
        wr_data = rd_data;
      end
      S_DUMP: begin
        rd_addr = out_free ? idx + IDX_W'(1) : idx;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      count     <= '0;
      found     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            case (cmd.command)
              CMD_INSERT: begin
                val <= cmd.value;
                if (count >= CNT_W'(DEPTH)) begin
                  resp_status <= ST_FULL;
                  state       <= S_RESP;
                end else if (count == '0) begin
                  idx   <= '0;
                  state <= S_INS_PUT;
                end else begin
                  idx   <= last_idx;
                  state <= S_INS;
                end
              end
              CMD_DELETE: begin
                val <= cmd.value;
                if (count == '0) begin
                  resp_status <= ST_EMPTY;
                  state       <= S_RESP;
                end else begin
                  idx   <= '0;
                  found <= 1'b0;
                  state <= S_DEL;
                end
              end
              CMD_DUMP: begin
                if (count == '0) begin
                  val         <= '0;
                  resp_status <= ST_EMPTY;
                  state       <= S_RESP;
                end else begin
                  idx   <= '0;
                  state <= S_DUMP;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_INS: begin
          if (greater) begin
            if (idx == '0) begin
              state <= S_INS_PUT;
            end else begin
              idx <= idx - IDX_W'(1);
            end
          end else begin
            count       <= count + CNT_W'(1);
            resp_status <= ST_OK;
            state       <= S_RESP;
          end
        end
        S_INS_PUT: begin
          count       <= count + CNT_W'(1);
          resp_status <= ST_OK;
          state       <= S_RESP;
        end
        S_DEL: begin
          if (idx == last_idx) begin
            if (found || match) begin
              count       <= count - CNT_W'(1);
              resp_status <= ST_OK;
            end else begin
              resp_status <= ST_NOT_FOUND;
            end
            state <= S_RESP;
          end else begin
            found <= found || match;
            idx   <= idx + IDX_W'(1);
          end
        end
        S_DUMP: begin
          if (out_free) begin
            res_value  <= $signed(rd_data);
            res_status <= ST_OK;
            res_count  <= COUNT_OUT_W'(count);
            res_last   <= idx == last_idx;
            if (idx == last_idx) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            res_value  <= val;
            res_status <= resp_status;
            res_count  <= COUNT_OUT_W'(count);
            res_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The list never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // Shifting never writes past the position just above the held entries.
  a_write_bound: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> {{(CNT_W-IDX_W){1'b0}}, wr_addr} <= count)
    else $error("RAM write beyond the held entries");

  // One command changes the count by at most one.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == $past(count)) || (count == $past(count) + CNT_W'(1)) ||
             (count == $past(count) - CNT_W'(1)))
    else $error("entry count jumped");

  // Only dump results that are not the final one come without last, and they are ok.
  a_not_last_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_last) |-> (res_status == ST_OK))
    else $error("non-final result with an error status");
`endif

endmodule

`default_nettype wire
